// ----- rtl/core/sharded_ring_queue_dispatch_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sharded ring queue dispatch block
// Shared property shapes used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SHARDED_RING_QUEUE_DISPATCH_ASSERT_SVH
`define SHARDED_RING_QUEUE_DISPATCH_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SRQD_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srqd assertion failed");

// Next-cycle implication, disabled during reset.
`define SRQD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srqd assertion failed");

`endif

// ----- rtl/core/srqd_pkg.sv -----
// ----------------------------------------------------------------------------
// srqd_pkg
// Sizes, codes and shared types of the sharded ring queue dispatch block.
// ----------------------------------------------------------------------------
package srqd_pkg;

   // Build-time sizing.
   localparam int MAX_SHARDS   = 8;
   localparam int RING_DEPTH   = 64;
   localparam int PAYLOAD_BITS = 64;

   localparam int MIN_QUEUE_CAPACITY = 2;
   localparam int MIN_SHARD_COUNT    = 1;

   // Field widths of the streams and registers.
   localparam int OP_W       = 1;
   localparam int SHARD_W    = 8;
   localparam int PAYLOAD_W  = 64;
   localparam int STATUS_W   = 3;
   localparam int DATA_W     = 64;
   localparam int DROP_W     = 32;
   localparam int ACTIVE_W   = 4;
   localparam int CAPACITY_W = 7;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 96;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 8;

   // Derived widths.
   localparam int SHARD_IDX_W = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;
   localparam int PTR_W       = $clog2(RING_DEPTH);
   localparam int MEM_DEPTH   = MAX_SHARDS * RING_DEPTH;
   localparam int ADDR_W      = $clog2(MEM_DEPTH);
   localparam int CAP_W       = $clog2(RING_DEPTH + 1);
   localparam int CMP_W       = (CAP_W > CAPACITY_W) ? CAP_W : CAPACITY_W;

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register reset values.
   localparam logic [ACTIVE_W-1:0]   ACTIVE_RESET   = 4'd8;
   localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 7'd64;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_ACTIVE_SHARDS = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RING_CAPACITY = 8'd1;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PUSH = 1'b0;
   localparam logic [OP_W-1:0] OP_POP  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_PUSHED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PUSH_BAD  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 3'd2;
   localparam logic [STATUS_W-1:0] ST_POPPED    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_POP_BAD   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 3'd5;

   // One classified item, handed from front to back.
   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic                    mem_write;
      logic                    mem_read;
      logic [ADDR_W-1:0]       addr;
      logic [PAYLOAD_BITS-1:0] payload;
      logic [DROP_W-1:0]       drop_total;
   } cmd_type;

   // Fill status of the command queue.
   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
      logic              empty;
   } qstat_type;

endpackage

// ----- rtl/core/srqd_front.sv -----
// ----------------------------------------------------------------------------
// srqd_front
// Accepts requests, checks them against the shard pointers, updates those
// pointers and the drop counter and hands a classified command to the queue.
// ----------------------------------------------------------------------------
module srqd_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [srqd_pkg::OP_W-1:0]       req_op,
   input  logic [srqd_pkg::SHARD_W-1:0]    req_shard,
   input  logic [srqd_pkg::PAYLOAD_W-1:0]  req_payload,
   input  logic                            csr_valid,
   input  logic [srqd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [srqd_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                            q_full,
   output logic                            cmd_valid,
   output srqd_pkg::cmd_type               cmd
);
   import srqd_pkg::*;

   // Next ring slot, wrapping at the effective capacity.
   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p,
                                                  input logic [CMP_W-1:0] cap);
      logic [CMP_W-1:0] sum;
      sum = CMP_W'(p) + CMP_W'(1);
      return (sum >= cap) ? '0 : PTR_W'(sum);
   endfunction

   logic [ACTIVE_W-1:0]   active_ff,   active_in;
   logic [CAPACITY_W-1:0] capacity_ff, capacity_in;
   logic [PTR_W-1:0]      wptr_ff [MAX_SHARDS];
   logic [PTR_W-1:0]      wptr_in [MAX_SHARDS];
   logic [PTR_W-1:0]      rptr_ff [MAX_SHARDS];
   logic [PTR_W-1:0]      rptr_in [MAX_SHARDS];
   logic [DROP_W-1:0]     drop_ff, drop_in;

   logic [SHARD_W-1:0]     act_ext, eff_shards;
   logic [CMP_W-1:0]       cap_ext, eff_cap;
   logic [SHARD_IDX_W-1:0] idx;
   logic [PTR_W-1:0]       w, r, nw;
   logic                   shard_ok, ring_full, ring_empty, accept;
   logic [DROP_W-1:0]      drop_inc;

   // Effective shard count and ring capacity.
   always_comb begin
      act_ext = SHARD_W'(active_ff);
      if (act_ext < SHARD_W'(MIN_SHARD_COUNT)) begin
         eff_shards = SHARD_W'(MIN_SHARD_COUNT);
      end else if (act_ext > SHARD_W'(MAX_SHARDS)) begin
         eff_shards = SHARD_W'(MAX_SHARDS);
      end else begin
         eff_shards = act_ext;
      end
      cap_ext = CMP_W'(capacity_ff);
      if (cap_ext < CMP_W'(MIN_QUEUE_CAPACITY)) begin
         eff_cap = CMP_W'(MIN_QUEUE_CAPACITY);
      end else if (cap_ext > CMP_W'(RING_DEPTH)) begin
         eff_cap = CMP_W'(RING_DEPTH);
      end else begin
         eff_cap = cap_ext;
      end
   end

   // Pointer lookup for the addressed shard.
   assign shard_ok   = req_shard < eff_shards;
   assign idx        = req_shard[SHARD_IDX_W-1:0];
   assign w          = wptr_ff[idx];
   assign r          = rptr_ff[idx];
   assign nw         = next_slot(w, eff_cap);
   assign ring_full  = nw == r;
   assign ring_empty = r == w;
   assign drop_inc   = (drop_ff != '1) ? drop_ff + DROP_W'(1) : drop_ff;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign cmd_valid = accept;

   // Classification and state update for one transfer.
   always_comb begin
      active_in   = active_ff;
      capacity_in = capacity_ff;
      wptr_in     = wptr_ff;
      rptr_in     = rptr_ff;
      drop_in     = drop_ff;

      cmd.status     = ST_PUSHED;
      cmd.mem_write  = 1'b0;
      cmd.mem_read   = 1'b0;
      cmd.addr       = ADDR_W'(idx * RING_DEPTH) + ADDR_W'(w);
      cmd.payload    = req_payload[PAYLOAD_BITS-1:0];

      if (req_op == OP_PUSH) begin
         if (!shard_ok) begin
            cmd.status = ST_PUSH_BAD;
            drop_in    = drop_inc;
         end else if (ring_full) begin
            cmd.status = ST_PUSH_FULL;
            drop_in    = drop_inc;
         end else begin
            cmd.status    = ST_PUSHED;
            cmd.mem_write = 1'b1;
            if (accept) begin
               wptr_in[idx] = nw;
            end
         end
      end else begin
         cmd.addr = ADDR_W'(idx * RING_DEPTH) + ADDR_W'(r);
         if (!shard_ok) begin
            cmd.status = ST_POP_BAD;
         end else if (ring_empty) begin
            cmd.status = ST_POP_EMPTY;
         end else begin
            cmd.status   = ST_POPPED;
            cmd.mem_read = 1'b1;
            if (accept) begin
               rptr_in[idx] = next_slot(r, eff_cap);
            end
         end
      end
      cmd.drop_total = drop_in;
      if (!accept) begin
         drop_in = drop_ff;
      end

      // A register write empties every ring and keeps the drop count.
      if (csr_valid) begin
         unique case (csr_index)
            REG_ACTIVE_SHARDS: begin
               active_in = csr_data[ACTIVE_W-1:0];
               wptr_in   = '{default: '0};
               rptr_in   = '{default: '0};
            end
            REG_RING_CAPACITY: begin
               capacity_in = csr_data[CAPACITY_W-1:0];
               wptr_in     = '{default: '0};
               rptr_in     = '{default: '0};
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= ACTIVE_RESET;
         capacity_ff <= CAPACITY_RESET;
         wptr_ff     <= '{default: '0};
         rptr_ff     <= '{default: '0};
         drop_ff     <= '0;
      end else begin
         active_ff   <= active_in;
         capacity_ff <= capacity_in;
         wptr_ff     <= wptr_in;
         rptr_ff     <= rptr_in;
         drop_ff     <= drop_in;
      end
   end

endmodule

// ----- rtl/core/srqd_queue.sv -----
// ----------------------------------------------------------------------------
// srqd_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module srqd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   input  srqd_pkg::cmd_type    wr_data,
   input  logic                 rd_ready,
   output logic                 rd_valid,
   output srqd_pkg::cmd_type    rd_data,
   output srqd_pkg::qstat_type  stat
);
   import srqd_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [QIDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_wr, do_rd;

   assign stat.count = count_ff;
   assign stat.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign stat.empty = count_ff == '0;

   assign rd_valid = !stat.empty;
   assign rd_data  = entry_ff[rd_idx_ff];

   assign do_wr = wr_valid && !stat.full;
   assign do_rd = rd_ready && !stat.empty;

   // Index and fill count bookkeeping.
   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_idx_in = (wr_idx_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_ff + QIDX_W'(1);
      end
      if (do_rd) begin
         rd_idx_in = (rd_idx_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_ff + QIDX_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_idx_ff] <= wr_data;
      end
   end

endmodule

// ----- rtl/core/srqd_back.sv -----
// ----------------------------------------------------------------------------
// srqd_back
// Carries out queued commands against the event memory and presents the
// result through an output register.
// ----------------------------------------------------------------------------
module srqd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  srqd_pkg::cmd_type             cmd,
   output logic                          cmd_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [srqd_pkg::STATUS_W-1:0] rsp_status,
   output logic [srqd_pkg::DATA_W-1:0]   rsp_data,
   output logic [srqd_pkg::DROP_W-1:0]   rsp_drop
);
   import srqd_pkg::*;

   logic [PAYLOAD_BITS-1:0] event_mem [MEM_DEPTH];
   logic [PAYLOAD_BITS-1:0] rdata_ff;

   logic                s1_valid_ff, s1_valid_in;
   logic [STATUS_W-1:0] s1_status_ff;
   logic [DROP_W-1:0]   s1_drop_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [DATA_W-1:0]   rsp_data_ff;
   logic [DROP_W-1:0]   rsp_drop_ff;

   logic s1_adv, pop;

   // Stage advance: the result register frees up or is taken this cycle.
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pop       = cmd_valid && (!s1_valid_ff || s1_adv);
   assign cmd_ready = pop;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pop) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Event memory: one write or one registered read per command.
   always_ff @(posedge clock) begin
      if (pop && cmd.mem_write) begin
         event_mem[cmd.addr] <= cmd.payload;
      end
      if (pop && cmd.mem_read) begin
         rdata_ff <= event_mem[cmd.addr];
      end
   end

   // Payload registers of both stages.
   always_ff @(posedge clock) begin
      if (pop) begin
         s1_status_ff <= cmd.status;
         s1_drop_ff   <= cmd.drop_total;
      end
      if (s1_adv) begin
         rsp_status_ff <= s1_status_ff;
         rsp_drop_ff   <= s1_drop_ff;
         rsp_data_ff   <= (s1_status_ff == ST_POPPED) ? DATA_W'(rdata_ff) : '0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_drop   = rsp_drop_ff;

endmodule

// ----- rtl/core/sharded_ring_queue_dispatch.sv -----
// ----------------------------------------------------------------------------
// sharded_ring_queue_dispatch
// Per-shard ring FIFOs of opaque events with push/pop requests and a
// saturating drop counter.
// ----------------------------------------------------------------------------
// The block takes one push or pop request per cycle while the command queue
// has room and returns exactly one result per request, in order, via the
// queue entry, the back's stage register and the result register. The rate
// is set by the front's pointer read and update per request and by the event
// memory, serving one write or one read per cycle in the back. A four-entry
// command queue and the result register let either side stall without losing
// a cycle. Any register write empties every ring; the drop count is kept.
// ----------------------------------------------------------------------------
`include "sharded_ring_queue_dispatch_assert.svh"

module sharded_ring_queue_dispatch (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [srqd_pkg::REQ_TDATA_W-1:0]  req_tdata,  // shard[7:0], payload[71:8]
   input  logic                              req_tuser,  // op[0]
   // Result stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [srqd_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // data[63:0], drop_total[95:64]
   output logic [srqd_pkg::STATUS_W-1:0]     rsp_tuser,  // status[2:0]
   // Register write channel.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [srqd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [srqd_pkg::CSR_DATA_W-1:0]   csr_data
);
   import srqd_pkg::*;

   cmd_type           front_cmd, queue_cmd;
   qstat_type         qstat;
   logic              front_valid, queue_valid, back_ready;
   logic [DATA_W-1:0] rsp_data;
   logic [DROP_W-1:0] rsp_drop;

   assign csr_ready = 1'b1;

   // Front: classify requests and update ring pointers.
   srqd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser),
      .req_shard   (req_tdata[SHARD_W-1:0]),
      .req_payload (req_tdata[SHARD_W+PAYLOAD_W-1:SHARD_W]),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_full      (qstat.full),
      .cmd_valid   (front_valid),
      .cmd         (front_cmd)
   );

   // Queue between front and back.
   srqd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_data  (front_cmd),
      .rd_ready (back_ready),
      .rd_valid (queue_valid),
      .rd_data  (queue_cmd),
      .stat     (qstat)
   );

   // Back: memory access and result register.
   srqd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (queue_valid),
      .cmd        (queue_cmd),
      .cmd_ready  (back_ready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_data   (rsp_data),
      .rsp_drop   (rsp_drop)
   );

   assign rsp_tdata = {rsp_drop, rsp_data};

   // Only a successful pop carries data.
   `SRQD_ASSERT_IMPLIES(a_data_zero_unless_popped, clock, reset, rsp_tvalid && (rsp_tuser != ST_POPPED), rsp_tdata[DATA_W-1:0] == '0)
   // The command queue never holds more than its depth.
   `SRQD_ASSERT_IMPLIES(a_queue_bound, clock, reset, 1'b1, qstat.count <= QCNT_W'(QUEUE_DEPTH))
   // An accepted request is in the queue on the following cycle.
   `SRQD_ASSERT_NEXT(a_accept_lands_in_queue, clock, reset, req_tvalid && req_tready, !qstat.empty)

endmodule
